@@ sv/anchor_box_generator_macros.svh @@
// Assertion macros shared by the anchor box generator RTL.
`ifndef ANCHOR_BOX_GENERATOR_MACROS_SVH
`define ANCHOR_BOX_GENERATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ABG_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ABG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/abg_pkg.sv @@
// Package: widths, register codes, shared types and helpers of the anchor box generator.
`default_nettype none

package abg_pkg;

    localparam int GRID_INDEX_BITS = 10;
    localparam int COORD_FRAC_BITS = 16;

    localparam int CELL_W      = GRID_INDEX_BITS;
    localparam int FIX_W       = 29;
    localparam int IMG_W       = 13;
    localparam int RECIP_W     = 63;
    localparam int RECIP_Y_W   = 32;
    localparam int RECIP_X_W   = RECIP_W - RECIP_Y_W;
    localparam int COORD_W     = 32;
    localparam int LANES       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = RECIP_W;

    localparam int PROD_W      = FIX_W + GRID_INDEX_BITS;
    localparam int CENTRE_W    = PROD_W + 1;
    localparam int CORNER_W    = CENTRE_W + 2;
    localparam int SCALE_W     = COORD_W + RECIP_Y_W + 1;
    localparam int ROUND_SHIFT = 31;

    localparam int MODE_CENTRE_BIT = 0;
    localparam int MODE_CLIP_BIT   = 1;
    localparam int MODE_NORM_BIT   = 2;

    localparam logic [FIX_W-1:0] STEP_RESET = FIX_W'(1) << COORD_FRAC_BITS;
    localparam logic [IMG_W-1:0] IMG_RESET  = IMG_W'(1);
    localparam logic signed [SCALE_W-1:0] ROUND_HALF = SCALE_W'(1) << (ROUND_SHIFT - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X     = 3'd0,
        CFG_ORIGIN_Y     = 3'd1,
        CFG_STEP_X       = 3'd2,
        CFG_STEP_Y       = 3'd3,
        CFG_IMAGE_WIDTH  = 3'd4,
        CFG_IMAGE_HEIGHT = 3'd5,
        CFG_RECIP_SIZES  = 3'd6,
        CFG_BOX_MODE     = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [FIX_W-1:0]     origin_x;
        logic [FIX_W-1:0]     origin_y;
        logic [FIX_W-1:0]     step_x;
        logic [FIX_W-1:0]     step_y;
        logic [IMG_W-1:0]     image_width;
        logic [IMG_W-1:0]     image_height;
        logic [RECIP_X_W-1:0] recip_x;
        logic [RECIP_Y_W-1:0] recip_y;
        logic                 centre_form;
        logic                 clip_on;
        logic                 norm_on;
    } cfg_t;

    // Cell centre and anchor size leaving the grid stages.
    typedef struct packed {
        logic [CENTRE_W-1:0] cx;
        logic [CENTRE_W-1:0] cy;
        logic [FIX_W-1:0]    bw;
        logic [FIX_W-1:0]    bh;
    } centre_t;

    // Four output coordinates (a, b, c, d) and the empty flag.
    typedef struct packed {
        logic [LANES-1:0][COORD_W-1:0] lane;
        logic                          empty;
    } coords_t;

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [SCALE_W-1:0] v
    );
        logic signed [SCALE_W-1:0] hi;
        logic signed [SCALE_W-1:0] lo;
        logic signed [COORD_W-1:0] r;
        hi = SCALE_W'({(COORD_W-1){1'b1}});
        lo = ~hi;
        if (v > hi) begin
            r = signed'(hi[COORD_W-1:0]);
        end else if (v < lo) begin
            r = signed'(lo[COORD_W-1:0]);
        end else begin
            r = signed'(v[COORD_W-1:0]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/abg_req_if.sv @@
// Interface: anchor request channel.
`default_nettype none

interface abg_req_if;
    logic                            valid;
    logic                            ready;
    logic [abg_pkg::CELL_W-1:0]      cell_row;
    logic [abg_pkg::CELL_W-1:0]      cell_col;
    logic [abg_pkg::FIX_W-1:0]       box_width;
    logic [abg_pkg::FIX_W-1:0]       box_height;

    modport source (output valid, output cell_row, output cell_col,
                    output box_width, output box_height, input ready);
    modport sink   (input valid, input cell_row, input cell_col,
                    input box_width, input box_height, output ready);
endinterface

`default_nettype wire

@@ sv/abg_rsp_if.sv @@
// Interface: anchor box result channel.
`default_nettype none

interface abg_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [abg_pkg::COORD_W-1:0] coord_a;
    logic signed [abg_pkg::COORD_W-1:0] coord_b;
    logic signed [abg_pkg::COORD_W-1:0] coord_c;
    logic signed [abg_pkg::COORD_W-1:0] coord_d;
    logic                              empty_box;

    modport source (output valid, output coord_a, output coord_b, output coord_c,
                    output coord_d, output empty_box, input ready);
    modport sink   (input valid, input coord_a, input coord_b, input coord_c,
                    input coord_d, input empty_box, output ready);
endinterface

`default_nettype wire

@@ sv/abg_cfg_if.sv @@
// Interface: configuration register write channel.
`default_nettype none

interface abg_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [abg_pkg::CFG_IDX_W-1:0]     index;
    logic [abg_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/abg_cfg.sv @@
// Configuration register bank.
`default_nettype none

module abg_cfg (
    input  logic          clk,
    input  logic          rst_n,
    abg_cfg_if.sink       cfg,
    output abg_pkg::cfg_t cfg_regs
);

    abg_pkg::cfg_t cfg_reg;
    abg_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_regs  = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (abg_pkg::cfg_index_t'(cfg.index))
                abg_pkg::CFG_ORIGIN_X:     cfg_next.origin_x = cfg.data[abg_pkg::FIX_W-1:0];
                abg_pkg::CFG_ORIGIN_Y:     cfg_next.origin_y = cfg.data[abg_pkg::FIX_W-1:0];
                abg_pkg::CFG_STEP_X:       cfg_next.step_x   = cfg.data[abg_pkg::FIX_W-1:0];
                abg_pkg::CFG_STEP_Y:       cfg_next.step_y   = cfg.data[abg_pkg::FIX_W-1:0];
                abg_pkg::CFG_IMAGE_WIDTH:
                    cfg_next.image_width  = cfg.data[abg_pkg::IMG_W-1:0];
                abg_pkg::CFG_IMAGE_HEIGHT:
                    cfg_next.image_height = cfg.data[abg_pkg::IMG_W-1:0];
                abg_pkg::CFG_RECIP_SIZES:
                begin
                    cfg_next.recip_x = cfg.data[abg_pkg::RECIP_W-1:abg_pkg::RECIP_Y_W];
                    cfg_next.recip_y = cfg.data[abg_pkg::RECIP_Y_W-1:0];
                end
                abg_pkg::CFG_BOX_MODE:
                begin
                    cfg_next.centre_form = cfg.data[abg_pkg::MODE_CENTRE_BIT];
                    cfg_next.clip_on     = cfg.data[abg_pkg::MODE_CLIP_BIT];
                    cfg_next.norm_on     = cfg.data[abg_pkg::MODE_NORM_BIT];
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_y     <= '0;
            cfg_reg.step_x       <= abg_pkg::STEP_RESET;
            cfg_reg.step_y       <= abg_pkg::STEP_RESET;
            cfg_reg.image_width  <= abg_pkg::IMG_RESET;
            cfg_reg.image_height <= abg_pkg::IMG_RESET;
            cfg_reg.recip_x      <= '0;
            cfg_reg.recip_y      <= '0;
            cfg_reg.centre_form  <= 1'b0;
            cfg_reg.clip_on      <= 1'b0;
            cfg_reg.norm_on      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/abg_grid.sv @@
// Grid stages: index times step, then origin added to give the cell centre.
`default_nettype none

`include "anchor_box_generator_macros.svh"

module abg_grid (
    input  logic             clk,
    input  logic             rst_n,
    input  abg_pkg::cfg_t    cfg_regs,
    abg_req_if.sink          req,
    output logic             out_valid,
    input  logic             out_ready,
    output abg_pkg::centre_t out_data
);

    logic                        p_valid_reg;
    logic                        p_ready;
    logic [abg_pkg::PROD_W-1:0]  p_col_prod_reg;
    logic [abg_pkg::PROD_W-1:0]  p_row_prod_reg;
    logic [abg_pkg::PROD_W-1:0]  p_col_prod_next;
    logic [abg_pkg::PROD_W-1:0]  p_row_prod_next;
    logic [abg_pkg::FIX_W-1:0]   p_bw_reg;
    logic [abg_pkg::FIX_W-1:0]   p_bh_reg;

    logic                        q_valid_reg;
    logic                        q_ready;
    abg_pkg::centre_t            q_data_reg;
    abg_pkg::centre_t            q_data_next;

    assign q_ready   = !q_valid_reg || out_ready;
    assign p_ready   = !p_valid_reg || q_ready;
    assign req.ready = p_ready;
    assign out_valid = q_valid_reg;
    assign out_data  = q_data_reg;

    always_comb
    begin
        p_col_prod_next = abg_pkg::PROD_W'(req.cell_col) * abg_pkg::PROD_W'(cfg_regs.step_x);
        p_row_prod_next = abg_pkg::PROD_W'(req.cell_row) * abg_pkg::PROD_W'(cfg_regs.step_y);
    end

    always_comb
    begin
        q_data_next.cx = abg_pkg::CENTRE_W'(cfg_regs.origin_x)
                       + abg_pkg::CENTRE_W'(p_col_prod_reg);
        q_data_next.cy = abg_pkg::CENTRE_W'(cfg_regs.origin_y)
                       + abg_pkg::CENTRE_W'(p_row_prod_reg);
        q_data_next.bw = p_bw_reg;
        q_data_next.bh = p_bh_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_ready)
            begin
                p_valid_reg <= req.valid;
            end
            if (q_ready)
            begin
                q_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_ready && req.valid)
        begin
            p_col_prod_reg <= p_col_prod_next;
            p_row_prod_reg <= p_row_prod_next;
            p_bw_reg       <= req.box_width;
            p_bh_reg       <= req.box_height;
        end
        if (q_ready && p_valid_reg)
        begin
            q_data_reg <= q_data_next;
        end
    end

    `ABG_ASSERT_NEXT(a_grid_stall_hold, q_valid_reg && !out_ready, q_valid_reg && $stable(q_data_reg), "grid centre changed under stall")

endmodule

`default_nettype wire

@@ sv/abg_box.sv @@
// Box stages: corners, clipping to the image when enabled, then output format and saturation.
`default_nettype none

`include "anchor_box_generator_macros.svh"

module abg_box (
    input  logic             clk,
    input  logic             rst_n,
    input  abg_pkg::cfg_t    cfg_regs,
    input  logic             in_valid,
    output logic             in_ready,
    input  abg_pkg::centre_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output abg_pkg::coords_t out_data
);

    typedef logic signed [abg_pkg::CORNER_W-1:0] corner_t;
    typedef logic signed [abg_pkg::CORNER_W:0]   corner_sum_t;

    function automatic corner_t clamp_to(input corner_t v, input corner_t lim);
        corner_t r;
        if (v[abg_pkg::CORNER_W-1])
        begin
            r = '0;
        end
        else if (v > lim)
        begin
            r = lim;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // stage A: corners
    logic             a_valid_reg;
    logic             a_ready;
    corner_t          a_x0_reg, a_x1_reg, a_y0_reg, a_y1_reg;
    corner_t          a_x0_next, a_x1_next, a_y0_next, a_y1_next;
    abg_pkg::centre_t a_ctr_reg;

    // stage B: corners, clipped when clipping is on
    logic             b_valid_reg;
    logic             b_ready;
    corner_t          b_x0_reg, b_x1_reg, b_y0_reg, b_y1_reg;
    corner_t          b_x0_next, b_x1_next, b_y0_next, b_y1_next;
    logic             b_clip_reg;
    logic             b_empty_reg;
    logic             b_empty_next;
    abg_pkg::centre_t b_ctr_reg;

    // stage C: formatted result
    logic             c_valid_reg;
    logic             c_ready;
    abg_pkg::coords_t c_data_reg;
    abg_pkg::coords_t c_data_next;

    corner_t     cx_s, cy_s, half_x, half_y;
    corner_t     lim_x, lim_y;
    corner_t     cl_x0, cl_x1, cl_y0, cl_y1;
    logic        empty_x, empty_y;
    corner_sum_t sum_x, sum_y;
    corner_sum_t mid_x, mid_y;
    logic signed [abg_pkg::SCALE_W-1:0] sel [abg_pkg::LANES];

    assign c_ready   = !c_valid_reg || out_ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_ready  = a_ready;
    assign out_valid = c_valid_reg;
    assign out_data  = c_data_reg;

    always_comb
    begin
        cx_s   = signed'(abg_pkg::CORNER_W'(in_data.cx));
        cy_s   = signed'(abg_pkg::CORNER_W'(in_data.cy));
        half_x = signed'(abg_pkg::CORNER_W'(in_data.bw[abg_pkg::FIX_W-1:1]));
        half_y = signed'(abg_pkg::CORNER_W'(in_data.bh[abg_pkg::FIX_W-1:1]));
        a_x0_next = cx_s - half_x;
        a_x1_next = cx_s + half_x;
        a_y0_next = cy_s - half_y;
        a_y1_next = cy_s + half_y;
    end

    always_comb
    begin
        lim_x = signed'(abg_pkg::CORNER_W'({cfg_regs.image_width,
                                            {abg_pkg::COORD_FRAC_BITS{1'b0}}}));
        lim_y = signed'(abg_pkg::CORNER_W'({cfg_regs.image_height,
                                            {abg_pkg::COORD_FRAC_BITS{1'b0}}}));
        cl_x0 = clamp_to(a_x0_reg, lim_x);
        cl_x1 = clamp_to(a_x1_reg, lim_x);
        cl_y0 = clamp_to(a_y0_reg, lim_y);
        cl_y1 = clamp_to(a_y1_reg, lim_y);
        empty_x = (cl_x1 <= cl_x0);
        empty_y = (cl_y1 <= cl_y0);
        if (cfg_regs.clip_on)
        begin
            b_x0_next    = cl_x0;
            b_x1_next    = empty_x ? cl_x0 : cl_x1;
            b_y0_next    = cl_y0;
            b_y1_next    = empty_y ? cl_y0 : cl_y1;
            b_empty_next = empty_x || empty_y;
        end
        else
        begin
            b_x0_next    = a_x0_reg;
            b_x1_next    = a_x1_reg;
            b_y0_next    = a_y0_reg;
            b_y1_next    = a_y1_reg;
            b_empty_next = 1'b0;
        end
    end

    always_comb
    begin
        // clipped corners are non-negative, so a plain shift is the floor
        sum_x = corner_sum_t'(b_x0_reg) + corner_sum_t'(b_x1_reg);
        sum_y = corner_sum_t'(b_y0_reg) + corner_sum_t'(b_y1_reg);
        mid_x = sum_x >>> 1;
        mid_y = sum_y >>> 1;
        if (cfg_regs.centre_form && b_clip_reg)
        begin
            sel[0] = abg_pkg::SCALE_W'(mid_x);
            sel[1] = abg_pkg::SCALE_W'(mid_y);
            sel[2] = abg_pkg::SCALE_W'(b_x1_reg - b_x0_reg);
            sel[3] = abg_pkg::SCALE_W'(b_y1_reg - b_y0_reg);
        end
        else if (cfg_regs.centre_form)
        begin
            sel[0] = signed'(abg_pkg::SCALE_W'(b_ctr_reg.cx));
            sel[1] = signed'(abg_pkg::SCALE_W'(b_ctr_reg.cy));
            sel[2] = signed'(abg_pkg::SCALE_W'(b_ctr_reg.bw));
            sel[3] = signed'(abg_pkg::SCALE_W'(b_ctr_reg.bh));
        end
        else
        begin
            sel[0] = abg_pkg::SCALE_W'(b_x0_reg);
            sel[1] = abg_pkg::SCALE_W'(b_x1_reg);
            sel[2] = abg_pkg::SCALE_W'(b_y0_reg);
            sel[3] = abg_pkg::SCALE_W'(b_y1_reg);
        end
        for (int k = 0; k < abg_pkg::LANES; k++)
        begin
            c_data_next.lane[k] = abg_pkg::sat_coord(sel[k]);
        end
        c_data_next.empty = b_empty_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_x0_reg  <= a_x0_next;
            a_x1_reg  <= a_x1_next;
            a_y0_reg  <= a_y0_next;
            a_y1_reg  <= a_y1_next;
            a_ctr_reg <= in_data;
        end
        if (b_ready && a_valid_reg)
        begin
            b_x0_reg    <= b_x0_next;
            b_x1_reg    <= b_x1_next;
            b_y0_reg    <= b_y0_next;
            b_y1_reg    <= b_y1_next;
            b_clip_reg  <= cfg_regs.clip_on;
            b_empty_reg <= b_empty_next;
            b_ctr_reg   <= a_ctr_reg;
        end
        if (c_ready && b_valid_reg)
        begin
            c_data_reg <= c_data_next;
        end
    end

    `ABG_ASSERT_IMPLY(a_clip_ordered, b_valid_reg && b_clip_reg, (b_x1_reg >= b_x0_reg) && (b_y1_reg >= b_y0_reg), "clipped box has max below min")
    `ABG_ASSERT_IMPLY(a_empty_needs_clip, b_valid_reg && b_empty_reg, b_clip_reg, "empty flag raised without clipping")

endmodule

`default_nettype wire

@@ sv/abg_norm.sv @@
// Normalize stages: when enabled, multiply by the reciprocal, then round half up and saturate; else pass through.
`default_nettype none

`include "anchor_box_generator_macros.svh"

module abg_norm (
    input  logic             clk,
    input  logic             rst_n,
    input  abg_pkg::cfg_t    cfg_regs,
    input  logic             in_valid,
    output logic             in_ready,
    input  abg_pkg::coords_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output abg_pkg::coords_t out_data
);

    logic                               d_valid_reg;
    logic                               d_ready;
    logic                               d_norm_reg;
    abg_pkg::coords_t                   d_pass_reg;
    logic signed [abg_pkg::SCALE_W-1:0] d_prod_reg  [abg_pkg::LANES];
    logic signed [abg_pkg::SCALE_W-1:0] d_prod_next [abg_pkg::LANES];

    logic                               e_valid_reg;
    logic                               e_ready;
    abg_pkg::coords_t                   e_res_reg;
    abg_pkg::coords_t                   e_res_next;

    logic [abg_pkg::RECIP_Y_W-1:0]      r_x;
    logic [abg_pkg::RECIP_Y_W-1:0]      r_sel [abg_pkg::LANES];
    logic signed [abg_pkg::SCALE_W-1:0] v_ext;
    logic signed [abg_pkg::RECIP_Y_W:0] r_ext;
    logic signed [abg_pkg::SCALE_W-1:0] rounded;

    assign e_ready   = !e_valid_reg || out_ready;
    assign d_ready   = !d_valid_reg || e_ready;
    assign in_ready  = d_ready;
    assign out_valid = e_valid_reg;
    assign out_data  = e_res_reg;

    always_comb
    begin
        // lane a is always x and lane d always y; b and c swap with the format
        r_x      = abg_pkg::RECIP_Y_W'(cfg_regs.recip_x);
        r_sel[0] = r_x;
        r_sel[1] = cfg_regs.centre_form ? cfg_regs.recip_y : r_x;
        r_sel[2] = cfg_regs.centre_form ? r_x : cfg_regs.recip_y;
        r_sel[3] = cfg_regs.recip_y;
        for (int k = 0; k < abg_pkg::LANES; k++)
        begin
            v_ext          = abg_pkg::SCALE_W'(signed'(in_data.lane[k]));
            r_ext          = signed'({1'b0, r_sel[k]});
            d_prod_next[k] = v_ext * r_ext;
        end
    end

    always_comb
    begin
        rounded    = '0;
        e_res_next = d_pass_reg;
        if (d_norm_reg)
        begin
            for (int k = 0; k < abg_pkg::LANES; k++)
            begin
                rounded            = (d_prod_reg[k] + abg_pkg::ROUND_HALF)
                                   >>> abg_pkg::ROUND_SHIFT;
                e_res_next.lane[k] = abg_pkg::sat_coord(rounded);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            if (d_ready)
            begin
                d_valid_reg <= in_valid;
            end
            if (e_ready)
            begin
                e_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && in_valid)
        begin
            d_norm_reg <= cfg_regs.norm_on;
            d_pass_reg <= in_data;
            for (int k = 0; k < abg_pkg::LANES; k++)
            begin
                d_prod_reg[k] <= d_prod_next[k];
            end
        end
        if (e_ready && d_valid_reg)
        begin
            e_res_reg <= e_res_next;
        end
    end

    `ABG_ASSERT_NEXT(a_out_stall_hold, e_valid_reg && !out_ready, e_valid_reg && $stable(e_res_reg), "result changed under stall")

endmodule

`default_nettype wire

@@ sv/anchor_box_generator.sv @@
// Top level: SSD style anchor box generator, seven register stages.
//
//   channel   dir   handshake          payload
//   req       in    valid / ready      cell_row, cell_col, box_width, box_height
//   rsp       out   valid / ready      coord_a..coord_d, empty_box
//   cfg       in    valid / ready      index, data (ready always high)
//
// One anchor per cycle sustained while rsp.ready stays high; the stages are: grid
// product, centre add, corners, clip, format, reciprocal multiply, round and
// saturate. Reset clears the valid bits and loads the register defaults.
// Under a stall each stage holds while full and fills while empty, so req.ready
// stays high until every stage holds an item.
`default_nettype none

module anchor_box_generator (
    input  logic       clk,
    input  logic       rst_n,
    abg_req_if.sink    req,
    abg_rsp_if.source  rsp,
    abg_cfg_if.sink    cfg
);

    abg_pkg::cfg_t    cfg_regs;

    logic             grid_valid;
    logic             grid_ready;
    abg_pkg::centre_t grid_data;

    logic             box_valid;
    logic             box_ready;
    abg_pkg::coords_t box_data;

    abg_pkg::coords_t res_data;

    abg_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_regs (cfg_regs)
    );

    abg_grid u_grid (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_regs  (cfg_regs),
        .req       (req),
        .out_valid (grid_valid),
        .out_ready (grid_ready),
        .out_data  (grid_data)
    );

    abg_box u_box (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_regs  (cfg_regs),
        .in_valid  (grid_valid),
        .in_ready  (grid_ready),
        .in_data   (grid_data),
        .out_valid (box_valid),
        .out_ready (box_ready),
        .out_data  (box_data)
    );

    abg_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_regs  (cfg_regs),
        .in_valid  (box_valid),
        .in_ready  (box_ready),
        .in_data   (box_data),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (res_data)
    );

    assign rsp.coord_a   = signed'(res_data.lane[0]);
    assign rsp.coord_b   = signed'(res_data.lane[1]);
    assign rsp.coord_c   = signed'(res_data.lane[2]);
    assign rsp.coord_d   = signed'(res_data.lane[3]);
    assign rsp.empty_box = res_data.empty;

endmodule

`default_nettype wire
